// File: design/lzfb_pkg.sv
// shared types and constants for the lz77 flag-block decompressor
package lzfb_pkg;

    localparam int HISTORY_DEPTH_DEF = 4096;
    localparam int CNT_W             = 24;
    localparam int LEN_W             = 5;
    localparam int DISP_W            = 13;
    localparam int MIN_MATCH         = 3;
    localparam logic [2:0] HDR_BYTES  = 3'd4;
    localparam logic [3:0] FLAG_UNITS = 4'd8;

    typedef enum logic {
        OP_LIT  = 1'b0,
        OP_COPY = 1'b1
    } op_kind_t;

    // one output byte request from the parser to the ring stage
    typedef struct packed {
        logic      valid;
        op_kind_t  kind;
        logic [7:0] lit;
        logic      err;
        logic      last;
        logic      done;
    } op_t;

    // one finished output word
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
        logic       err;
    } res_t;

    // parser status seen by the top level
    typedef struct packed {
        logic copy_busy;
        logic active;
    } pstat_t;

endpackage

// File: design/lzfb_parser.sv
// stream parser: header, flag bytes, back-references and copy sequencer
module lzfb_parser #(
    parameter int HISTORY_DEPTH = lzfb_pkg::HISTORY_DEPTH_DEF,
    localparam int AW = $clog2(HISTORY_DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_data,
    input  logic               in_start,
    input  logic               can_issue,
    output lzfb_pkg::op_t      op,
    output logic [AW-1:0]      rd_addr,
    output logic [AW-1:0]      wr_addr,
    output lzfb_pkg::pstat_t   status
);

    localparam logic [AW:0]   DEPTH_W = (AW+1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_IX = AW'(HISTORY_DEPTH - 1);

    logic [2:0]                     hdr_idx_reg, hdr_idx_next;
    logic [lzfb_pkg::CNT_W-1:0]     total_reg, total_next;
    logic [lzfb_pkg::CNT_W-1:0]     produced_reg, produced_next;
    logic [7:0]                     flags_reg, flags_next;
    logic [3:0]                     units_reg, units_next;
    logic [7:0]                     ref_hi_reg, ref_hi_next;
    logic                           ref_pend_reg, ref_pend_next;
    logic                           active_reg, active_next;
    logic [AW-1:0]                  wp_reg, wp_next;
    logic [lzfb_pkg::LEN_W-1:0]     copy_left_reg, copy_left_next;
    logic [lzfb_pkg::DISP_W-1:0]    copy_disp_reg, copy_disp_next;
    logic [AW-1:0]                  copy_src_reg, copy_src_next;

    always_comb
    begin
        logic [lzfb_pkg::DISP_W-1:0] disp;
        logic [lzfb_pkg::LEN_W-1:0]  len;
        logic [AW:0]                 wp_ext;
        logic [AW:0]                 disp_ext;
        logic [AW:0]                 src_ext;
        logic [AW-1:0]               wp_inc;
        logic [AW-1:0]               src_inc;
        logic [lzfb_pkg::CNT_W-1:0]  prod_inc;
        logic [2:0]                  h_idx;
        logic [lzfb_pkg::CNT_W-1:0]  tot;
        logic [lzfb_pkg::CNT_W-1:0]  prod;
        logic [7:0]                  flags;
        logic [3:0]                  units;
        logic [7:0]                  hi;
        logic                        pend;
        logic                        act;

        hdr_idx_next   = hdr_idx_reg;
        total_next     = total_reg;
        produced_next  = produced_reg;
        flags_next     = flags_reg;
        units_next     = units_reg;
        ref_hi_next    = ref_hi_reg;
        ref_pend_next  = ref_pend_reg;
        active_next    = active_reg;
        wp_next        = wp_reg;
        copy_left_next = copy_left_reg;
        copy_disp_next = copy_disp_reg;
        copy_src_next  = copy_src_reg;

        op      = '0;
        op.kind = lzfb_pkg::OP_LIT;
        rd_addr = copy_src_reg;
        wr_addr = wp_reg;

        // back-reference decode from the held first byte and this byte
        disp     = {1'b0, ref_hi_reg[3:0], in_data} + lzfb_pkg::DISP_W'(1);
        len      = {1'b0, ref_hi_reg[7:4]} + lzfb_pkg::LEN_W'(lzfb_pkg::MIN_MATCH);
        wp_ext   = {1'b0, wp_reg};
        disp_ext = (AW+1)'(disp);
        if (wp_ext >= disp_ext)
            src_ext = wp_ext - disp_ext;
        else
            src_ext = wp_ext + DEPTH_W - disp_ext;

        wp_inc  = (wp_reg == LAST_IX) ? '0 : wp_reg + 1'b1;
        src_inc = (copy_src_reg == LAST_IX) ? '0 : copy_src_reg + 1'b1;
        prod_inc = produced_reg + 1'b1;

        in_ready = (copy_left_reg == '0) && can_issue;

        h_idx = hdr_idx_reg;
        tot   = total_reg;
        prod  = produced_reg;
        flags = flags_reg;
        units = units_reg;
        hi    = ref_hi_reg;
        pend  = ref_pend_reg;
        act   = active_reg;

        if (copy_left_reg != '0) begin
            if (can_issue) begin
                op.valid       = 1'b1;
                op.kind        = lzfb_pkg::OP_COPY;
                op.err         = lzfb_pkg::CNT_W'(copy_disp_reg) > produced_reg;
                op.done        = prod_inc >= total_reg;
                op.last        = (copy_left_reg == lzfb_pkg::LEN_W'(1)) || op.done;
                produced_next  = prod_inc;
                wp_next        = wp_inc;
                copy_src_next  = src_inc;
                copy_left_next = op.done ? '0 : copy_left_reg - 1'b1;
                if (op.done)
                    active_next = 1'b0;
            end
        end else if (in_valid && in_ready) begin
            if (in_start) begin
                h_idx = '0;
                tot   = '0;
                prod  = '0;
                flags = '0;
                units = '0;
                hi    = '0;
                pend  = 1'b0;
                act   = 1'b1;
            end
            if (act) begin
                if (h_idx < lzfb_pkg::HDR_BYTES) begin
                    case (h_idx)
                        3'd1:    tot[7:0]   = in_data;
                        3'd2:    tot[15:8]  = in_data;
                        3'd3:    tot[23:16] = in_data;
                        default: ;
                    endcase
                    h_idx = h_idx + 1'b1;
                    if ((h_idx == lzfb_pkg::HDR_BYTES) && (tot == '0))
                        act = 1'b0;
                end else if (pend) begin
                    pend  = 1'b0;
                    units = (units != '0) ? units - 1'b1 : '0;
                    copy_left_next = len;
                    copy_disp_next = disp;
                    copy_src_next  = src_ext[AW-1:0];
                end else if (units == '0) begin
                    flags = in_data;
                    units = lzfb_pkg::FLAG_UNITS;
                end else if (flags[7]) begin
                    flags = {flags[6:0], 1'b0};
                    hi    = in_data;
                    pend  = 1'b1;
                end else begin
                    flags    = {flags[6:0], 1'b0};
                    units    = units - 1'b1;
                    prod     = prod + 1'b1;
                    op.valid = 1'b1;
                    op.kind  = lzfb_pkg::OP_LIT;
                    op.lit   = in_data;
                    op.last  = 1'b1;
                    op.done  = prod >= tot;
                    wp_next  = wp_inc;
                    if (op.done)
                        act = 1'b0;
                end
            end
            hdr_idx_next  = h_idx;
            total_next    = tot;
            produced_next = prod;
            flags_next    = flags;
            units_next    = units;
            ref_hi_next   = hi;
            ref_pend_next = pend;
            active_next   = act;
        end
    end

    assign status.copy_busy = (copy_left_reg != '0);
    assign status.active    = active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hdr_idx_reg   <= '0;
            total_reg     <= '0;
            produced_reg  <= '0;
            flags_reg     <= '0;
            units_reg     <= '0;
            ref_hi_reg    <= '0;
            ref_pend_reg  <= 1'b0;
            active_reg    <= 1'b0;
            wp_reg        <= '0;
            copy_left_reg <= '0;
        end else begin
            hdr_idx_reg   <= hdr_idx_next;
            total_reg     <= total_next;
            produced_reg  <= produced_next;
            flags_reg     <= flags_next;
            units_reg     <= units_next;
            ref_hi_reg    <= ref_hi_next;
            ref_pend_reg  <= ref_pend_next;
            active_reg    <= active_next;
            wp_reg        <= wp_next;
            copy_left_reg <= copy_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        copy_disp_reg <= copy_disp_next;
        copy_src_reg  <= copy_src_next;
    end

endmodule

// File: design/lzfb_ring.sv
// history ring memory with write-back stage and read forwarding
module lzfb_ring #(
    parameter int HISTORY_DEPTH = lzfb_pkg::HISTORY_DEPTH_DEF,
    localparam int AW = $clog2(HISTORY_DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lzfb_pkg::op_t     op,
    input  logic [AW-1:0]     rd_addr,
    input  logic [AW-1:0]     wr_addr,
    output lzfb_pkg::res_t    res,
    output logic              res_valid
);

    logic [7:0]     history_mem [HISTORY_DEPTH];
    logic [7:0]     rd_q_reg;
    lzfb_pkg::op_t  s2_op_reg;
    logic [AW-1:0]  s2_wr_reg;
    logic           fwd_hit_reg, fwd_hit_next;
    logic [7:0]     fwd_data_reg;
    logic [7:0]     byte_val;
    logic           rd_en;

    assign rd_en = op.valid && (op.kind == lzfb_pkg::OP_COPY);

    always_comb
    begin
        case (s2_op_reg.kind)
            lzfb_pkg::OP_LIT:  byte_val = s2_op_reg.lit;
            lzfb_pkg::OP_COPY: byte_val = s2_op_reg.err ? 8'h00 :
                                          (fwd_hit_reg ? fwd_data_reg : rd_q_reg);
            default:           byte_val = s2_op_reg.lit;
        endcase
    end

    // a read issued now at the address written now would see the old byte
    assign fwd_hit_next = s2_op_reg.valid && rd_en && (s2_wr_reg == rd_addr);

    assign res_valid = s2_op_reg.valid;
    assign res.data  = byte_val;
    assign res.last  = s2_op_reg.last;
    assign res.done  = s2_op_reg.done;
    assign res.err   = s2_op_reg.err;

    always_ff @(posedge clk)
    begin
        if (s2_op_reg.valid)
            history_mem[s2_wr_reg] <= byte_val;
        if (rd_en)
            rd_q_reg <= history_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s2_op_reg   <= '0;
            fwd_hit_reg <= 1'b0;
        end else begin
            s2_op_reg   <= op;
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_wr_reg    <= wr_addr;
        fwd_data_reg <= byte_val;
    end

endmodule

// File: design/lzfb_outq.sv
// two-entry output queue decoupling the ring stage from the output channel
module lzfb_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lzfb_pkg::res_t  push_data,
    input  logic            pop_ready,
    output logic            out_valid,
    output lzfb_pkg::res_t  out_data,
    output logic            pop,
    output logic [1:0]      count
);

    lzfb_pkg::res_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && pop_ready;
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/lz77_flag_block_decompressor_top.sv
// lz77 flag-block decompressor: header, flag and back-reference decode over a history ring
// output path: an issued byte passes the ring stage register and then the output queue
// throughput: while the output queue has room, header, flag and literal bytes are taken
//   one per cycle; a back-reference's two bytes are taken likewise, and its 3 to 18 copied
//   bytes then follow one per cycle, paced by the single read port of the history ring memory
// reset: asynchronous, active low; clears all decoder and queue control state
//   but not the ring memory, whose entries reach the output only after being written
module lz77_flag_block_decompressor_top #(
    parameter int HISTORY_DEPTH = lzfb_pkg::HISTORY_DEPTH_DEF,
    localparam int AW = $clog2(HISTORY_DEPTH)
) (
    input  logic        clk,
    input  logic        rst_n,
    // compressed input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] start_req
    // decompressed output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // last word caused by one input word
    output logic [1:0]  m_axis_tuser    // [0] stream_done, [1] ref_error
);

    lzfb_pkg::op_t    op;
    lzfb_pkg::res_t   res;
    lzfb_pkg::res_t   q_data;
    lzfb_pkg::pstat_t pstat;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic             res_valid;
    logic             q_pop;
    logic [1:0]       q_count;
    logic [2:0]       credit;
    logic             can_issue;

    // an issued byte is held in the ring stage register before it lands in the queue; only issue when the
    // queue is sure to have room even if the output stalls
    assign credit    = 3'(q_count) + 3'(res_valid) - 3'(q_pop);
    assign can_issue = (credit < 3'd2);

    // parser: header length, flag bits, literal and copy sequencing
    lzfb_parser #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_start  (s_axis_tuser),
        .can_issue (can_issue),
        .op        (op),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .status    (pstat)
    );

    // history ring: read for copies, write-back of every output byte
    lzfb_ring #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .res       (res),
        .res_valid (res_valid)
    );

    // output queue toward the master side
    lzfb_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (q_data),
        .pop       (q_pop),
        .count     (q_count)
    );

    assign m_axis_tdata    = q_data.data;
    assign m_axis_tlast    = q_data.last;
    assign m_axis_tuser[0] = q_data.done;
    assign m_axis_tuser[1] = q_data.err;

    // the queue never receives a word while full and not draining
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (q_count != 2'd2 || q_pop))
        else $error("output queue overflow");

    // no input word is taken while a copy is still being issued
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> !pstat.copy_busy)
        else $error("input accepted during copy");

    // a copy only runs inside an active stream
    assert property (@(posedge clk) disable iff (!rst_n)
        pstat.copy_busy |-> pstat.active)
        else $error("copy outside an active stream");

    // the word that completes a stream always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("stream done without last");

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the lz77 flag-block decompressor, with its own decoder model
`timescale 1ns / 1ps

module tb_top;

    localparam int HIST          = lzfb_pkg::HISTORY_DEPTH_DEF;
    localparam int AW            = $clog2(HIST);
    localparam int RANDOM_ITEMS  = 280;
    localparam int CYCLE_LIMIT   = 2_000_000;
    // bit positions inside m_axis_tuser
    localparam int DONE_BIT      = 0;
    localparam int ERR_BIT       = 1;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tuser = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [1:0] m_axis_tuser;

    lz77_flag_block_decompressor_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // decoder model state, advanced once per accepted input word
    // ------------------------------------------------------------------
    logic [2:0]    dec_hdr_idx  = '0;
    logic [23:0]   dec_total    = '0;
    logic [23:0]   dec_produced = '0;
    logic [7:0]    dec_flags    = '0;
    logic [3:0]    dec_units    = '0;
    logic [7:0]    dec_ref_hi   = '0;
    logic          dec_ref_pend = 1'b0;
    logic          dec_active   = 1'b0;
    logic [AW-1:0] dec_wptr     = '0;
    logic [7:0]    dec_ring [0:HIST-1];

    lzfb_pkg::res_t step_words[$];    // output words caused by the word just decoded
    lzfb_pkg::res_t pending_out[$];   // output words still owed by the block

    // directed rows: typed rows carry their own expectation (zero or one word),
    // the others take whatever the decoder model works out
    typedef struct packed {
        logic [7:0]     b;
        logic           s;
        logic           typed;
        logic           tcnt;
        lzfb_pkg::res_t w;
    } stim_row_t;

    localparam lzfb_pkg::res_t NO_WORD = '0;
    localparam int             N_DIR   = 27;

    stim_row_t dir_rows [0:N_DIR-1] = '{
        '{8'hFF, 1'b0, 1'b1, 1'b0, NO_WORD},                        // idle word after reset
        '{8'h10, 1'b1, 1'b1, 1'b0, NO_WORD},                        // header, length zero
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_WORD},                        // stream ends silently
        '{8'h10, 1'b1, 1'b1, 1'b0, NO_WORD},                        // header, length 8
        '{8'h08, 1'b0, 1'b1, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_WORD},
        '{8'h60, 1'b0, 1'b1, 1'b0, NO_WORD},                        // flags: lit, copy, copy
        '{8'h00, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},     // literal zero
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_WORD},                        // copy, shortest length
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_WORD},                        // distance 1, overlapping
        '{8'hFF, 1'b0, 1'b1, 1'b0, NO_WORD},                        // copy, longest length
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_WORD},                        // distance 4096: before start,
                                                                    // cut off at the length
        '{8'h55, 1'b0, 1'b1, 1'b0, NO_WORD},                        // ignored after completion
        '{8'h10, 1'b1, 1'b1, 1'b0, NO_WORD},                        // header, largest length
        '{8'hFF, 1'b0, 1'b1, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, 1'b1, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, 1'b1, 1'b0, NO_WORD},
        '{8'hEF, 1'b1, 1'b1, 1'b0, NO_WORD},                        // restart while awaiting flags
        '{8'h02, 1'b0, 1'b1, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_WORD},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_WORD},
        '{8'h80, 1'b0, 1'b1, 1'b0, NO_WORD},                        // flags: copy first
        '{8'h7F, 1'b0, 1'b1, 1'b0, NO_WORD},                        // copy of 10, far distance
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_WORD}                         // all bytes flagged, cut at 2
    };

    // what the driver has on the bus right now, seen by the checker at acceptance
    logic           drv_typed = 1'b0;
    logic           drv_tcnt  = 1'b0;
    lzfb_pkg::res_t drv_word  = '0;

    int unsigned errors     = 0;
    int unsigned cycles     = 0;
    int unsigned busy_items = 0;
    int unsigned rx_hold    = 0;
    logic        tx_quiet   = 1'b0;
    logic        rx_quiet   = 1'b0;

    initial begin
        for (int i = 0; i < HIST; i++)
            dec_ring[i] = 8'h00;
    end

    // one output byte of the model: through the ring, counted against the length
    task automatic put_word(input logic [7:0] v, input logic e);
        lzfb_pkg::res_t w;
        dec_ring[dec_wptr] = v;
        dec_wptr++;
        dec_produced++;
        w.data = v;
        w.last = 1'b0;
        w.err  = e;
        w.done = (dec_produced >= dec_total);
        if (w.done)
            dec_active = 1'b0;
        step_words.push_back(w);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic s);
        int unsigned    run_len;
        logic [12:0]    disp;
        logic [AW-1:0]  src;
        lzfb_pkg::res_t w;
        step_words.delete();
        if (s) begin
            // restart: decoder state clears, ring and write pointer stay
            dec_hdr_idx  = '0;
            dec_total    = '0;
            dec_produced = '0;
            dec_flags    = '0;
            dec_units    = '0;
            dec_ref_hi   = '0;
            dec_ref_pend = 1'b0;
            dec_active   = 1'b1;
        end
        if (!dec_active)
            return;
        if (dec_hdr_idx < lzfb_pkg::HDR_BYTES) begin
            // type byte first, then the length little-endian
            if (dec_hdr_idx != 0)
                dec_total = dec_total | (24'(b) << (8 * (dec_hdr_idx - 1)));
            dec_hdr_idx++;
            if (dec_hdr_idx == lzfb_pkg::HDR_BYTES && dec_total == 0)
                dec_active = 1'b0;
            return;
        end
        if (dec_ref_pend) begin
            run_len      = dec_ref_hi[7:4] + lzfb_pkg::MIN_MATCH;
            disp         = {dec_ref_hi[3:0], b} + 13'd1;
            dec_ref_pend = 1'b0;
            if (dec_units != 0)
                dec_units--;
            for (int i = 0; i < run_len && dec_active; i++) begin
                if (disp <= dec_produced) begin
                    src = dec_wptr - disp[AW-1:0];
                    put_word(dec_ring[src], 1'b0);
                end else begin
                    put_word(8'h00, 1'b1);
                end
            end
        end else if (dec_units == 0) begin
            dec_flags = b;
            dec_units = lzfb_pkg::FLAG_UNITS;
        end else if (lzfb_pkg::op_kind_t'(dec_flags[7]) == lzfb_pkg::OP_COPY) begin
            dec_flags    = dec_flags << 1;
            dec_ref_hi   = b;
            dec_ref_pend = 1'b1;
        end else begin
            dec_flags = dec_flags << 1;
            dec_units--;
            put_word(b, 1'b0);
        end
        if (step_words.size() != 0) begin
            w      = step_words.pop_back();
            w.last = 1'b1;
            step_words.push_back(w);
        end
    endtask

    // pause lengths for both sides: mostly none or short, now and then long
    function automatic int unsigned pick_pause(input logic quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(20, 50);
    endfunction

    task automatic cmp_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            errors++;
        end
    endtask

    // cycle count, timeout, and switching the idle patterns on and off
    always @(posedge clk) begin
        cycles++;
        if (cycles % 256 == 0) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: ready drops for random stretches
    always @(negedge clk) begin
        if (rx_hold != 0) begin
            m_axis_tready <= 1'b0;
            rx_hold--;
        end else begin
            m_axis_tready <= 1'b1;
            rx_hold = pick_pause(rx_quiet);
        end
    end

    // model update on every accepted input word, check on every accepted output word
    lzfb_pkg::res_t due;
    always @(posedge clk) begin
        if (rst_n && s_axis_tvalid && s_axis_tready) begin
            decode_byte(s_axis_tdata, s_axis_tuser);
            if (drv_typed) begin
                if (drv_tcnt)
                    pending_out.push_back(drv_word);
            end else begin
                foreach (step_words[i])
                    pending_out.push_back(step_words[i]);
            end
        end
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_out.size() == 0) begin
                $display("%0t: output word %h with none expected, expected nothing, got %h",
                         $time, m_axis_tdata, m_axis_tdata);
                errors++;
            end else begin
                due = pending_out.pop_front();
                cmp_field("out_byte", due.data, m_axis_tdata);
                cmp_field("last_of_run", 8'(due.last), 8'(m_axis_tlast));
                cmp_field("stream_done", 8'(due.done), 8'(m_axis_tuser[DONE_BIT]));
                cmp_field("ref_error", 8'(due.err), 8'(m_axis_tuser[ERR_BIT]));
            end
        end
    end

    // drive one word from a falling edge, return at the falling edge after acceptance
    task automatic send_word(input logic [7:0] b, input logic s, input logic typed = 1'b0,
                             input logic tcnt = 1'b0, input lzfb_pkg::res_t w = '0);
        int unsigned gap;
        gap = pick_pause(tx_quiet);
        if (s || dec_active)
            busy_items++;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= s;
        drv_typed     <= typed;
        drv_tcnt      <= tcnt;
        drv_word      <= w;
        @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready))
            @(posedge clk);
        @(negedge clk);
    endtask

    // sender holds off until every owed word is out, then lets the block settle
    task automatic wait_drained(input int unsigned settle);
        s_axis_tvalid <= 1'b0;
        while (pending_out.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // one well-formed stream with random content, sometimes cut off early
    task automatic send_stream();
        int unsigned len, abort_at, sent, disp, avail, r;
        logic [7:0]  b;
        logic [7:0]  low_pending;
        logic [3:0]  len_nib;
        logic [11:0] dist_code;
        r = $urandom_range(0, 99);
        if (r < 6)
            len = 0;
        else if (r < 70)
            len = $urandom_range(1, 40);
        else if (r < 96)
            len = $urandom_range(41, 300);
        else
            len = $urandom_range(301, 700);
        abort_at    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : 0;
        sent        = 0;
        low_pending = 8'h00;
        for (int i = 0; i < lzfb_pkg::HDR_BYTES; i++) begin
            b = (i == 0) ? 8'($urandom) : 8'(len >> (8 * (i - 1)));
            send_word(b, i == 0);
            sent++;
            if (sent == abort_at)
                return;
        end
        while (dec_active) begin
            if (dec_ref_pend) begin
                b = low_pending;
            end else if (dec_units == 0) begin
                r = $urandom_range(0, 99);
                b = (r < 30) ? 8'hFF : (r < 40) ? 8'h00 : 8'($urandom);
            end else if (lzfb_pkg::op_kind_t'(dec_flags[7]) == lzfb_pkg::OP_COPY) begin
                len_nib = ($urandom_range(0, 9) < 4) ? 4'hF : 4'($urandom);
                avail   = (dec_produced < HIST) ? dec_produced : HIST;
                // mostly reachable distances, mostly short, some reaching before start
                if (avail > 0 && $urandom_range(0, 9) != 0)
                    disp = ($urandom_range(0, 9) < 7) ?
                           $urandom_range(1, (avail < 20) ? avail : 20) :
                           $urandom_range(1, avail);
                else
                    disp = $urandom_range(1, HIST);
                dist_code   = 12'(disp - 1);
                b           = {len_nib, dist_code[11:8]};
                low_pending = dist_code[7:0];
            end else begin
                b = 8'($urandom);
            end
            send_word(b, 1'b0);
            sent++;
            // a long stream is left unfinished once the word budget is spent
            if (sent == abort_at || busy_items >= RANDOM_ITEMS)
                return;
        end
        // stray words after completion are dropped by the block
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b0);
    endtask

    initial begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        for (int i = 0; i < N_DIR; i++)
            send_word(dir_rows[i].b, dir_rows[i].s, dir_rows[i].typed, dir_rows[i].tcnt,
                      dir_rows[i].w);
        wait_drained(8);

        // random part: streams, broken streams and loose noise words
        busy_items = 0;
        while (busy_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 6)
                repeat ($urandom_range(1, 4))
                    send_word(8'($urandom), $urandom_range(0, 7) == 0);
            else
                send_stream();
            if ($urandom_range(0, 7) == 0)
                wait_drained(6);
        end

        wait_drained(12);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
